/* sv/isots_pkg.sv */
package isots_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_RANGE     = 3'd2,
        ST_DAY       = 3'd3,
        ST_OVERFLOW  = 3'd4
    } isots_status_t;

    // Fields of one complete timestamp, handed from the scanner to the converter.
    typedef struct packed {
        logic        bad;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] frac;
        logic [3:0]  frac_count;
    } isots_fields_t;

    // Characters of the fixed pattern.
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Positions of the separators and the length of the fixed part.
    localparam logic [4:0] POS_DASH_A  = 5'd4;
    localparam logic [4:0] POS_DASH_B  = 5'd7;
    localparam logic [4:0] POS_T       = 5'd10;
    localparam logic [4:0] POS_COLON_A = 5'd13;
    localparam logic [4:0] POS_COLON_B = 5'd16;
    localparam logic [4:0] FIXED_LEN   = 5'd19;

    localparam logic [3:0] FRAC_DIGITS = 4'd9;

    // Days in a month, February without leap day.
    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        case (m) inside
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Days from March 1 to the first of the month, in a March-based year.
    function automatic logic [8:0] march_days(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            4'd12:   d = 9'd275;
            4'd1:    d = 9'd306;
            4'd2:    d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Scale that pads a fraction of n digits out to nanoseconds.
    function automatic logic [29:0] frac_scale(input logic [3:0] n);
        logic [29:0] s;
        case (n)
            4'd0:    s = 30'd1000000000;
            4'd1:    s = 30'd100000000;
            4'd2:    s = 30'd10000000;
            4'd3:    s = 30'd1000000;
            4'd4:    s = 30'd100000;
            4'd5:    s = 30'd10000;
            4'd6:    s = 30'd1000;
            4'd7:    s = 30'd100;
            4'd8:    s = 30'd10;
            default: s = 30'd1;
        endcase
        return s;
    endfunction

endpackage

/* sv/isots_scanner.sv */
module isots_scanner (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_text_byte,
    input  logic                    s_end_of_text,
    output logic                    f_valid,
    input  logic                    f_ready,
    output isots_pkg::isots_fields_t f_fields
);
    import isots_pkg::*;

    typedef enum logic [3:0] {
        PH_FIELDS = 4'b0001,
        PH_SEEK   = 4'b0010,
        PH_FRAC   = 4'b0100,
        PH_TAIL   = 4'b1000
    } isots_phase_t;

    isots_phase_t  phase_reg, phase_next;
    logic [4:0]    pos_reg, pos_next;
    logic [13:0]   year_reg, year_next;
    logic [6:0]    month_reg, month_next;
    logic [6:0]    day_reg, day_next;
    logic [6:0]    hour_reg, hour_next;
    logic [6:0]    minute_reg, minute_next;
    logic [6:0]    second_reg, second_next;
    logic [29:0]   frac_reg, frac_next;
    logic [3:0]    count_reg, count_next;
    logic          malformed_reg, malformed_next;
    logic          f_valid_reg;
    isots_fields_t fields_reg, fields_next;
    logic          is_digit;
    logic [3:0]    digit;
    logic          take;

    assign take    = s_valid && s_ready;
    assign s_ready = !f_valid_reg || f_ready;

    // Decode the incoming character.
    always_comb begin
        is_digit = (s_text_byte >= CHAR_ZERO) && (s_text_byte <= CHAR_NINE);
        digit    = is_digit ? 4'(s_text_byte - CHAR_ZERO) : 4'd0;
    end

    // Next scanner state for the incoming character.
    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        frac_next      = frac_reg;
        count_next     = count_reg;
        malformed_next = malformed_reg;
        unique case (phase_reg)
            PH_FIELDS: begin
                if (pos_reg == POS_DASH_A || pos_reg == POS_DASH_B) begin
                    if (s_text_byte != CHAR_DASH) malformed_next = 1'b1;
                end else if (pos_reg == POS_T) begin
                    if (s_text_byte != CHAR_T) malformed_next = 1'b1;
                end else if (pos_reg == POS_COLON_A || pos_reg == POS_COLON_B) begin
                    if (s_text_byte != CHAR_COLON) malformed_next = 1'b1;
                end else begin
                    if (!is_digit) malformed_next = 1'b1;
                    if (pos_reg < POS_DASH_A) begin
                        year_next = year_reg * 14'd10 + {10'd0, digit};
                    end else if (pos_reg < POS_DASH_B) begin
                        month_next = month_reg * 7'd10 + {3'd0, digit};
                    end else if (pos_reg < POS_T) begin
                        day_next = day_reg * 7'd10 + {3'd0, digit};
                    end else if (pos_reg < POS_COLON_A) begin
                        hour_next = hour_reg * 7'd10 + {3'd0, digit};
                    end else if (pos_reg < POS_COLON_B) begin
                        minute_next = minute_reg * 7'd10 + {3'd0, digit};
                    end else begin
                        second_next = second_reg * 7'd10 + {3'd0, digit};
                    end
                end
                pos_next = pos_reg + 5'd1;
                if (pos_next == FIXED_LEN) phase_next = PH_SEEK;
            end
            PH_SEEK: begin
                if (s_text_byte == CHAR_DOT) phase_next = PH_FRAC;
            end
            PH_FRAC: begin
                if (is_digit) begin
                    if (count_reg < FRAC_DIGITS) begin
                        frac_next  = frac_reg * 30'd10 + {26'd0, digit};
                        count_next = count_reg + 4'd1;
                    end
                end else begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL: begin
            end
            default: begin
            end
        endcase
    end

    // Snapshot of the finished timestamp.
    always_comb begin
        fields_next.bad        = (phase_next == PH_FIELDS) || malformed_next;
        fields_next.year       = year_next;
        fields_next.month      = month_next;
        fields_next.day        = day_next;
        fields_next.hour       = hour_next;
        fields_next.minute     = minute_next;
        fields_next.second     = second_next;
        fields_next.frac       = frac_next;
        fields_next.frac_count = count_next;
    end

    // Scanner state; the last character of a timestamp returns it to reset.
    always_ff @(posedge aclk) begin
        if (!aresetn || (take && s_end_of_text)) begin
            phase_reg     <= PH_FIELDS;
            pos_reg       <= '0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            frac_reg      <= '0;
            count_reg     <= '0;
            malformed_reg <= 1'b0;
        end else if (take) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            frac_reg      <= frac_next;
            count_reg     <= count_next;
            malformed_reg <= malformed_next;
        end
    end

    // Hand-off register toward the converter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_ready) begin
            f_valid_reg <= s_valid && s_end_of_text;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && s_end_of_text) begin
            fields_reg <= fields_next;
        end
    end

    assign f_valid  = f_valid_reg;
    assign f_fields = fields_reg;

endmodule

/* sv/isots_convert.sv */
module isots_convert (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     f_valid,
    output logic                     f_ready,
    input  isots_pkg::isots_fields_t f_fields,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [63:0]       m_epoch_nanoseconds,
    output logic [2:0]               m_status
);
    import isots_pkg::*;

    // Stage enables: a stage moves when it is empty or its successor moves.
    logic out_en, e_en, d_en, c_en, b_en;
    logic b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, m_valid_reg;

    assign out_en  = !m_valid_reg || m_ready;
    assign e_en    = !e_valid_reg || out_en;
    assign d_en    = !d_valid_reg || e_en;
    assign c_en    = !c_valid_reg || d_en;
    assign b_en    = !b_valid_reg || c_en;
    assign f_ready = b_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (b_en)   b_valid_reg <= f_valid;
            if (c_en)   c_valid_reg <= b_valid_reg;
            if (d_en)   d_valid_reg <= c_valid_reg;
            if (e_en)   e_valid_reg <= d_valid_reg;
            if (out_en) m_valid_reg <= e_valid_reg;
        end
    end

    // Field checks, shifted year, day of year, time of day and padded fraction.
    logic          range_bad, feb_or_jan, hundred, leap, day_bad;
    logic [25:0]   year_q_prod, yy_q_prod;
    logic [6:0]    year_q100;
    logic [13:0]   yy_next;
    logic [4:0]    mdays;
    logic [59:0]   frac_prod;
    isots_status_t b_status_next;
    logic [9:0]    doy_next;
    logic [18:0]   tod_next;

    isots_status_t b_status_reg;
    logic [13:0]   b_yy_reg;
    logic [6:0]    b_q100_reg;
    logic [9:0]    b_doy_reg;
    logic [18:0]   b_tod_reg;
    logic [29:0]   b_frac_reg;

    always_comb begin
        range_bad = (f_fields.month < 7'd1) || (f_fields.month > 7'd12) ||
                    (f_fields.day < 7'd1) || (f_fields.day > 7'd31) ||
                    (f_fields.hour > 7'd23) || (f_fields.minute > 7'd59) ||
                    (f_fields.second > 7'd60);
        feb_or_jan  = (f_fields.month <= 7'd2);
        // Quotient by 100 through a reciprocal, exact below 43699.
        year_q_prod = {12'd0, f_fields.year} * 26'd5243;
        year_q100   = year_q_prod[25:19];
        hundred     = (f_fields.year == {7'd0, year_q100} * 14'd100);
        leap        = ((f_fields.year[1:0] == 2'd0) && !hundred) ||
                      (hundred && (year_q100[1:0] == 2'd0));
        mdays       = (f_fields.month == 7'd2 && leap) ? 5'd29 :
                      month_length(f_fields.month[3:0]);
        day_bad     = f_fields.day > {2'd0, mdays};
        if (f_fields.bad) begin
            b_status_next = ST_MALFORMED;
        end else if (range_bad) begin
            b_status_next = ST_RANGE;
        end else if (day_bad) begin
            b_status_next = ST_DAY;
        end else begin
            b_status_next = ST_OK;
        end
        yy_next   = f_fields.year + 14'd400 - {13'd0, feb_or_jan};
        yy_q_prod = {12'd0, yy_next} * 26'd5243;
        doy_next  = {1'b0, march_days(f_fields.month[3:0])} + {3'd0, f_fields.day} - 10'd1;
        tod_next  = {12'd0, f_fields.hour} * 19'd3600 + {12'd0, f_fields.minute} * 19'd60 +
                    {12'd0, f_fields.second};
        frac_prod = {30'd0, f_fields.frac} * {30'd0, frac_scale(f_fields.frac_count)};
    end

    always_ff @(posedge aclk) begin
        if (b_en) begin
            b_status_reg <= b_status_next;
            b_yy_reg     <= yy_next;
            b_q100_reg   <= yy_q_prod[25:19];
            b_doy_reg    <= doy_next;
            b_tod_reg    <= tod_next;
            b_frac_reg   <= frac_prod[29:0];
        end
    end

    // Days since the epoch from the March-based year.
    logic [21:0]        day_sum;
    logic signed [23:0] days_next;

    isots_status_t      c_status_reg;
    logic signed [23:0] c_days_reg;
    logic [18:0]        c_tod_reg;
    logic [29:0]        c_frac_reg;

    always_comb begin
        day_sum   = {8'd0, b_yy_reg} * 22'd365 + {10'd0, b_yy_reg[13:2]} - {15'd0, b_q100_reg} +
                    {17'd0, b_q100_reg[6:2]} + {12'd0, b_doy_reg};
        days_next = $signed({2'b00, day_sum}) - 24'sd865565;
    end

    always_ff @(posedge aclk) begin
        if (c_en) begin
            c_status_reg <= b_status_reg;
            c_days_reg   <= days_next;
            c_tod_reg    <= b_tod_reg;
            c_frac_reg   <= b_frac_reg;
        end
    end

    // Seconds since the epoch.
    logic signed [41:0] secs_next;

    isots_status_t      d_status_reg;
    logic signed [41:0] d_secs_reg;
    logic [29:0]        d_frac_reg;

    always_comb begin
        secs_next = c_days_reg * 18'sd86400 + $signed({23'd0, c_tod_reg});
    end

    always_ff @(posedge aclk) begin
        if (d_en) begin
            d_status_reg <= c_status_reg;
            d_secs_reg   <= secs_next;
            d_frac_reg   <= c_frac_reg;
        end
    end

    // Range check against the 64-bit limit and the two partial products.
    logic               overflow;
    logic signed [21:0] secs_hi;
    logic signed [52:0] hi_prod_next;
    logic [49:0]        lo_prod_next;
    isots_status_t      e_status_next;

    isots_status_t      e_status_reg;
    logic signed [52:0] e_hi_prod_reg;
    logic [49:0]        e_lo_prod_reg;
    logic [29:0]        e_frac_reg;

    always_comb begin
        overflow = (d_secs_reg > 42'sd9223372036) ||
                   ((d_secs_reg == 42'sd9223372036) && (d_frac_reg > 30'd854775807)) ||
                   (d_secs_reg < -42'sd9223372037) ||
                   ((d_secs_reg == -42'sd9223372037) && (d_frac_reg < 30'd145224192));
        e_status_next = (d_status_reg == ST_OK && overflow) ? ST_OVERFLOW : d_status_reg;
        secs_hi       = d_secs_reg[41:20];
        hi_prod_next  = secs_hi * 31'sd1000000000;
        lo_prod_next  = {30'd0, d_secs_reg[19:0]} * 50'd1000000000;
    end

    always_ff @(posedge aclk) begin
        if (e_en) begin
            e_status_reg  <= e_status_next;
            e_hi_prod_reg <= hi_prod_next;
            e_lo_prod_reg <= lo_prod_next;
            e_frac_reg    <= d_frac_reg;
        end
    end

    // Final sum into the result register; any failing status gives zero.
    logic [63:0]   ns_next;
    logic [63:0]   m_ns_reg;
    isots_status_t m_status_reg;

    always_comb begin
        ns_next = {e_hi_prod_reg[43:0], 20'd0} + {14'd0, e_lo_prod_reg} + {34'd0, e_frac_reg};
        if (e_status_reg != ST_OK) ns_next = 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_ns_reg     <= ns_next;
            m_status_reg <= e_status_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_epoch_nanoseconds = $signed(m_ns_reg);
    assign m_status            = m_status_reg;

endmodule

/* sv/iso8601_timestamp_to_epoch_ns_top.sv */
// A timestamp's fields pass the scanner hand-off register, stages b, c, d, e and
// the result register to m_valid. One character is taken per cycle while s_ready
// is high. The five-stage conversion pipeline (field checks, day count, seconds,
// split 1e9 product, sum) takes a new timestamp every cycle while results drain.
// Reset: aresetn low, synchronous; clears the scanner and all valid flags.
module iso8601_timestamp_to_epoch_ns_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    input  logic               s_end_of_text,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_epoch_nanoseconds,
    output logic [2:0]         m_status
);
    import isots_pkg::*;

    logic          f_valid;
    logic          f_ready;
    isots_fields_t f_fields;

    // Character scanner and field accumulators.
    isots_scanner u_scanner (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .f_valid       (f_valid),
        .f_ready       (f_ready),
        .f_fields      (f_fields)
    );

    // Checks and conversion to nanoseconds.
    isots_convert u_convert (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .f_valid             (f_valid),
        .f_ready             (f_ready),
        .f_fields            (f_fields),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_epoch_nanoseconds (m_epoch_nanoseconds),
        .m_status            (m_status)
    );

endmodule

/* bench/tb_top.sv */
module tb_top;
    import isots_pkg::*;

    localparam int CLK_HALF          = 4;
    localparam int RESET_CYCLES      = 7;
    localparam int RANDOM_BYTES      = 950;
    localparam int MIN_RANDOM_STAMPS = 30;
    localparam int IDLE_LIMIT        = 1000;
    localparam int DRAIN_CYCLES      = 20;
    localparam int MAX_WAIT          = 8;

    // Where the scanner is within one timestamp text.
    typedef enum logic [3:0] {
        SCAN_FIELDS   = 4'b0001,
        SCAN_SEEK_DOT = 4'b0010,
        SCAN_FRACTION = 4'b0100,
        SCAN_TRAILER  = 4'b1000
    } scan_phase_t;

    typedef struct {
        longint        nanos;
        isots_status_t status;
    } epoch_result_t;

    // Tracks the text as the block sees it and holds the epochs it must produce.
    class epoch_scoreboard;
        logic [4:0]      position;
        logic [13:0]     year;
        logic [6:0]      month;
        logic [6:0]      day;
        logic [6:0]      hour;
        logic [6:0]      minute;
        logic [6:0]      second;
        logic [29:0]     fraction;
        logic [3:0]      fraction_digits;
        scan_phase_t     phase;
        logic            pattern_broken;
        epoch_result_t   expected_epochs[$];
        int              errors;
        int              status_count[5];

        function new();
            errors = 0;
            foreach (status_count[i]) status_count[i] = 0;
            restart();
        endfunction

        function void restart();
            position        = '0;
            year            = '0;
            month           = '0;
            day             = '0;
            hour            = '0;
            minute          = '0;
            second          = '0;
            fraction        = '0;
            fraction_digits = '0;
            phase           = SCAN_FIELDS;
            pattern_broken  = 1'b0;
        endfunction

        function int pending();
            return expected_epochs.size();
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CHAR_ZERO && c <= CHAR_NINE;
        endfunction

        function bit leap_year(int y);
            return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
        endfunction

        function int month_day_count(int m, int y);
            if (m == 2) return leap_year(y) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
            return 31;
        endfunction

        // Day count relative to 1970-01-01, shifted by one 400-year era to stay positive.
        function longint days_since_epoch(int y, int m, int d);
            longint yy;
            longint era;
            longint yoe;
            longint mp;
            longint doy;
            longint doe;
            yy  = y + 400 - ((m <= 2) ? 1 : 0);
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = (m + 9) % 12;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468 - 146097;
        endfunction

        // One character of the fixed YYYY-MM-DDTHH:MM:SS part.
        function void take_fixed(logic [7:0] c);
            int unsigned d;
            d = is_digit(c) ? c - CHAR_ZERO : 0;
            case (position) inside
                POS_DASH_A, POS_DASH_B: if (c != CHAR_DASH) pattern_broken = 1'b1;
                POS_T: if (c != CHAR_T) pattern_broken = 1'b1;
                POS_COLON_A, POS_COLON_B: if (c != CHAR_COLON) pattern_broken = 1'b1;
                default: begin
                    if (!is_digit(c)) pattern_broken = 1'b1;
                    // Accumulators wrap at their register widths.
                    if (position < POS_DASH_A) year = 14'(year * 10 + d);
                    else if (position < POS_DASH_B) month = 7'(month * 10 + d);
                    else if (position < POS_T) day = 7'(day * 10 + d);
                    else if (position < POS_COLON_A) hour = 7'(hour * 10 + d);
                    else if (position < POS_COLON_B) minute = 7'(minute * 10 + d);
                    else second = 7'(second * 10 + d);
                end
            endcase
            position = position + 1'b1;
            if (position >= FIXED_LEN) begin
                position = FIXED_LEN;
                phase    = SCAN_SEEK_DOT;
            end
        endfunction

        // Builds the status and epoch for the timestamp just closed.
        function epoch_result_t convert_stamp();
            epoch_result_t r;
            int            y;
            int            mo;
            int            dd;
            longint        secs;
            longint        padded;
            int            n;
            y  = year;
            mo = month;
            dd = day;
            r.nanos = 0;
            if (phase == SCAN_FIELDS || pattern_broken) begin
                r.status = ST_MALFORMED;
            end else if (mo < 1 || mo > 12 || dd < 1 || dd > 31 || hour > 23 ||
                         minute > 59 || second > 60) begin
                r.status = ST_RANGE;
            end else if (dd > month_day_count(mo, y)) begin
                r.status = ST_DAY;
            end else begin
                secs = days_since_epoch(y, mo, dd) * 86400 + longint'(int'(hour)) * 3600 +
                       longint'(int'(minute)) * 60 + longint'(int'(second));
                padded = fraction;
                for (n = fraction_digits; n < 9; n++) padded = padded * 10;
                if (secs > 64'sd9223372036 || (secs == 64'sd9223372036 && padded > 854775807) ||
                    secs < -64'sd9223372037 ||
                    (secs == -64'sd9223372037 && padded < 145224192)) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    r.status = ST_OK;
                    r.nanos  = secs * 64'sd1000000000 + padded;
                end
            end
            return r;
        endfunction

        // Called for every accepted input transaction.
        function void note_byte(logic [7:0] c, logic last);
            unique case (phase)
                SCAN_FIELDS: take_fixed(c);
                SCAN_SEEK_DOT: if (c == CHAR_DOT) phase = SCAN_FRACTION;
                SCAN_FRACTION: begin
                    if (is_digit(c)) begin
                        if (fraction_digits < FRAC_DIGITS) begin
                            fraction        = 30'(fraction * 10 + (c - CHAR_ZERO));
                            fraction_digits = fraction_digits + 1'b1;
                        end
                    end else begin
                        phase = SCAN_TRAILER;
                    end
                end
                default: ;
            endcase
            if (last) begin
                expected_epochs.push_back(convert_stamp());
                restart();
            end
        endfunction

        // Called for every accepted result transaction.
        function void check_result(logic signed [63:0] nanos, logic [2:0] status);
            epoch_result_t want;
            if (expected_epochs.size() == 0) begin
                $display("%0t: unexpected result, epoch_nanoseconds %0d status %0d",
                         $time, nanos, status);
                errors++;
                return;
            end
            want = expected_epochs.pop_front();
            status_count[int'(want.status)]++;
            if (status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, status);
                errors++;
            end
            if (nanos !== want.nanos) begin
                $display("%0t: epoch_nanoseconds mismatch, expected %0d, actual %0d",
                         $time, want.nanos, nanos);
                errors++;
            end
        endfunction
    endclass

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [7:0]         s_text_byte   = 8'h00;
    logic               s_end_of_text = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic signed [63:0] m_epoch_nanoseconds;
    logic [2:0]         m_status;

    epoch_scoreboard epochs = new();

    logic [7:0] stamp_text[$];
    logic       sender_steady = 1'b0;
    int         bytes_sent    = 0;
    int         stamps_sent   = 0;

    iso8601_timestamp_to_epoch_ns_top u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_text_byte         (s_text_byte),
        .s_end_of_text       (s_end_of_text),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_epoch_nanoseconds (m_epoch_nanoseconds),
        .m_status            (m_status)
    );

    always #CLK_HALF aclk = ~aclk;

    // Text building helpers.
    function automatic void put_string(string s);
        int k;
        for (k = 0; k < s.len(); k++) stamp_text.push_back(s[k]);
    endfunction

    function automatic void put_number(int value, int digits);
        int scale;
        scale = 1;
        repeat (digits - 1) scale *= 10;
        repeat (digits) begin
            stamp_text.push_back(8'(CHAR_ZERO + (value / scale) % 10));
            scale /= 10;
        end
    endfunction

    // One input transaction, with a random gap ahead of it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_text <= last;
        do @(posedge aclk); while (!(s_valid && s_ready));
        epochs.note_byte(b, last);
        bytes_sent++;
    endtask

    // Sends the text built so far, marking its final character.
    task automatic send_stamp();
        int k;
        sender_steady = ($urandom_range(0, 3) == 0);
        for (k = 0; k < stamp_text.size(); k++) send_byte(stamp_text[k], k == stamp_text.size() - 1);
        stamp_text.delete();
        stamps_sent++;
    endtask

    task automatic send_text(input string s);
        put_string(s);
        send_stamp();
    endtask

    // Holds the input side off until every pending result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (epochs.pending() != 0);
    endtask

    // Mostly well-formed timestamps with random fields, plus broken ones and noise.
    task automatic make_random_stamp();
        int kind;
        int n;
        int ss;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            n = $urandom_range(1, 30);
            repeat (n) stamp_text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        put_number(($urandom_range(0, 4) == 0) ? $urandom_range(0, 9999)
                                               : $urandom_range(1678, 2261), 4);
        put_string("-");
        put_number(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12), 2);
        put_string("-");
        put_number(($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31), 2);
        put_string("T");
        put_number(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23), 2);
        put_string(":");
        put_number(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
        put_string(":");
        ss = $urandom_range(0, 59);
        if ($urandom_range(0, 9) == 0) ss = 60;
        else if ($urandom_range(0, 9) == 0) ss = $urandom_range(0, 99);
        put_number(ss, 2);
        // Text between the fixed part and the fraction.
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) stamp_text.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) < 6) begin
            put_string(".");
            n = $urandom_range(0, 12);
            repeat (n) stamp_text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) stamp_text.push_back(8'($urandom_range(0, 255)));
        end
        // Break the fixed part: either a random character or an early end.
        if (kind < 30) begin
            if ($urandom_range(0, 1) == 1) begin
                stamp_text[$urandom_range(0, 18)] = 8'($urandom_range(0, 255));
            end else begin
                n = $urandom_range(1, 18);
                while (stamp_text.size() > n) void'(stamp_text.pop_back());
            end
        end
    endtask

    // Result side: random stalls, with stretches where ready stays high.
    initial begin : receiver
        int   stall;
        logic steady;
        steady = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 7) == 0) steady = !steady;
            stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            epochs.check_result(m_epoch_nanoseconds, m_status);
        end
    end

    // Ends the run when no transaction completes for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int random_stamps;
        int random_bytes;
        random_stamps = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Epoch, both ends of the 64-bit range and one step past each.
        send_text("1970-01-01T00:00:00");
        send_text("1677-09-21T00:12:43.145224192");
        send_text("1677-09-21T00:12:43.145224191");
        send_text("2262-04-11T23:47:16.854775807Z");
        send_text("2262-04-11T23:47:16.854775808");
        // Extreme years, leap seconds, long and short fractions.
        send_text("0000-02-29T00:00:00");
        send_text("9999-12-31T23:59:60");
        send_text("2016-12-31T23:59:60.5");
        send_text("2000-02-29T12:00:00.123456789123");
        // Day beyond month, including a century that is not a leap year.
        send_text("1900-02-29T00:00:00");
        send_text("2023-04-31T00:00:00");
        // Month, day, hour, minute and second just outside their ranges, then far outside.
        send_text("2023-00-10T00:00:00");
        send_text("2023-13-10T00:00:00");
        send_text("2023-01-00T00:00:00");
        send_text("2023-01-32T00:00:00");
        send_text("2023-01-01T24:00:00");
        send_text("2023-01-01T23:60:00");
        send_text("2023-01-01T23:59:61");
        send_text("1999-99-99T99:99:99");
        // Malformed text, short text, and malformed taking priority over range.
        send_text("2023-01-01 00:00:00");
        send_text("20a3/01-01T00:00:00");
        send_text("2023-13-01X00:00:00");
        send_text("2023-01-01T00:00");
        send_text("1");
        // Text before the fraction, extra dots after it, NUL and high bytes.
        send_text("2023-06-15T08:30:00+02:00.25.7");
        put_string("2001-09-09T01:46:40");
        stamp_text.push_back(8'h00);
        stamp_text.push_back(8'hFF);
        put_string(".9");
        stamp_text.push_back(8'h00);
        send_stamp();
        wait_for_results();

        random_bytes = bytes_sent;
        while (bytes_sent - random_bytes < RANDOM_BYTES || random_stamps < MIN_RANDOM_STAMPS) begin
            make_random_stamp();
            if ($urandom_range(0, 11) == 0) wait_for_results();
            send_stamp();
            random_stamps++;
        end
        s_valid <= 1'b0;

        while (epochs.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d timestamps in %0d characters; results by status: %0d ok, %0d malformed,",
                 stamps_sent, bytes_sent, epochs.status_count[ST_OK],
                 epochs.status_count[ST_MALFORMED]);
        $display("%0d out of range, %0d day beyond month, %0d overflow; %0d mismatches.",
                 epochs.status_count[ST_RANGE], epochs.status_count[ST_DAY],
                 epochs.status_count[ST_OVERFLOW], epochs.errors);
        if (epochs.errors == 0 && epochs.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* iso8601_timestamp_to_epoch_ns_top.f */
sv/isots_pkg.sv
sv/isots_scanner.sv
sv/isots_convert.sv
sv/iso8601_timestamp_to_epoch_ns_top.sv
bench/tb_top.sv
